### rtl/trv_pkg.sv
// shared types, constants and round function for the trivium stream cipher
package trv_pkg;

    localparam int STATE_WORDS  = 10;
    localparam int WORD_W       = 32;
    localparam int WARM_ROUNDS  = 4 * 9;
    localparam int WARM_CNT_W   = $clog2(WARM_ROUNDS);
    localparam logic [7:0] IV_CONST = 8'h70;
    localparam int MAX_BYTES    = 10;

    localparam logic [2:0] CFG_KEY_LOW   = 3'd0;
    localparam logic [2:0] CFG_KEY_HIGH  = 3'd1;
    localparam logic [2:0] CFG_IV_LOW    = 3'd2;
    localparam logic [2:0] CFG_IV_HIGH   = 3'd3;
    localparam logic [2:0] CFG_KEY_BYTES = 3'd4;
    localparam logic [2:0] CFG_IV_BYTES  = 3'd5;

    localparam logic OP_INIT = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef logic [STATE_WORDS-1:0][WORD_W-1:0] t_state;

    typedef struct packed {
        t_state            state;
        logic [WORD_W-1:0] z;
    } t_round;

    // controller to datapath commands
    typedef struct packed {
        logic load_init;
        logic run_data;
        logic run_warm;
        logic set_init_out;
    } t_cmd;

    // 32 state bits ending at register position b, base is the position of lo bit 0
    function automatic logic [WORD_W-1:0] tap(input logic [WORD_W-1:0] hi,
                                              input logic [WORD_W-1:0] lo,
                                              input int unsigned base,
                                              input int unsigned b);
        logic [2*WORD_W-1:0] cat;
        cat = {hi, lo} >> (b - base);
        return cat[WORD_W-1:0];
    endfunction

    // 32 rounds in parallel
    function automatic t_round rounds32(input t_state s);
        t_round r;
        logic [WORD_W-1:0] t1, t2, t3;
        t1 = tap(s[2], s[1], 64, 66) ^ tap(s[2], s[1], 64, 93);
        t2 = tap(s[5], s[4], 64, 69) ^ tap(s[5], s[4], 64, 84);
        t3 = tap(s[8], s[7], 64, 66) ^ tap(s[9], s[8], 96, 111);
        r.z = t1 ^ t2 ^ t3;
        t1 = t1 ^ (tap(s[2], s[1], 64, 91) & tap(s[2], s[1], 64, 92))
                ^ tap(s[5], s[4], 64, 78);
        t2 = t2 ^ (tap(s[5], s[4], 64, 82) & tap(s[5], s[4], 64, 83))
                ^ tap(s[8], s[7], 64, 87);
        t3 = t3 ^ (tap(s[9], s[8], 96, 109) & tap(s[9], s[8], 96, 110))
                ^ tap(s[2], s[1], 64, 69);
        r.state    = s;
        r.state[2] = s[1];
        r.state[1] = s[0];
        r.state[0] = t3;
        r.state[5] = s[4];
        r.state[4] = s[3];
        r.state[3] = t1;
        r.state[9] = s[8];
        r.state[8] = s[7];
        r.state[7] = s[6];
        r.state[6] = t2;
        return r;
    endfunction

    // 80-bit value with bytes at and above len cleared, as 96 bits
    function automatic logic [3*WORD_W-1:0] load80(input logic [63:0] lo,
                                                  input logic [15:0] hi,
                                                  input logic [3:0]  len);
        logic [79:0] v;
        logic [79:0] m;
        v = {hi, lo};
        for (int i = 0; i < MAX_BYTES; i++) begin
            m[8*i +: 8] = (len > 4'(i)) ? 8'hFF : 8'h00;
        end
        return {16'h0000, v & m};
    endfunction

    function automatic logic [WORD_W-1:0] byte_mask(input logic [2:0] cnt);
        logic [WORD_W-1:0] m;
        case (cnt)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

### rtl/trv_datapath.sv
// trivium state, configuration registers and result register
module trv_datapath import trv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    output logic [31:0] o_result_word,
    output logic        o_init_done
);

    t_state      r_state, n_state;
    logic [63:0] r_key_low, r_iv_low;
    logic [15:0] r_key_high, r_iv_high;
    logic [3:0]  r_key_bytes, r_iv_bytes;
    logic [31:0] r_result, n_result;
    logic        r_init_done, n_init_done;

    t_round             w_round;
    logic [3*WORD_W-1:0] w_key;
    logic [3*WORD_W-1:0] w_iv;

    assign w_round = rounds32(r_state);
    assign w_key   = load80(r_key_low, r_key_high, r_key_bytes);
    assign w_iv    = load80(r_iv_low, r_iv_high, r_iv_bytes);

    always_comb begin
        n_state     = r_state;
        n_result    = r_result;
        n_init_done = r_init_done;
        if (i_cmd.load_init) begin
            n_state[0] = w_key[31:0];
            n_state[1] = w_key[63:32];
            n_state[2] = w_key[95:64];
            n_state[3] = w_iv[31:0];
            n_state[4] = w_iv[63:32];
            n_state[5] = w_iv[95:64];
            n_state[6] = '0;
            n_state[7] = '0;
            n_state[8] = '0;
            n_state[9] = {16'h0000, IV_CONST, 8'h00};
        end else if (i_cmd.run_warm) begin
            n_state = w_round.state;
        end else if (i_cmd.run_data) begin
            if (i_byte_count != 3'd0) begin
                n_state = w_round.state;
            end
            n_result    = (i_data_word ^ w_round.z) & byte_mask(i_byte_count);
            n_init_done = 1'b0;
        end
        if (i_cmd.set_init_out) begin
            n_result    = '0;
            n_init_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_key_low   <= '0;
            r_key_high  <= '0;
            r_iv_low    <= '0;
            r_iv_high   <= '0;
            r_key_bytes <= 4'(MAX_BYTES);
            r_iv_bytes  <= 4'(MAX_BYTES);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY_LOW:   r_key_low   <= i_cfg_data;
                    CFG_KEY_HIGH:  r_key_high  <= i_cfg_data[15:0];
                    CFG_IV_LOW:    r_iv_low    <= i_cfg_data;
                    CFG_IV_HIGH:   r_iv_high   <= i_cfg_data[15:0];
                    CFG_KEY_BYTES: r_key_bytes <= i_cfg_data[3:0];
                    CFG_IV_BYTES:  r_iv_bytes  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result    <= n_result;
        r_init_done <= n_init_done;
    end

    assign o_result_word = r_result;
    assign o_init_done   = r_init_done;

endmodule

### rtl/trv_ctrl.sv
// request sequencing: accept, warm-up count and result handshake
module trv_ctrl import trv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_opcode,
    input  logic i_out_stall,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WARM = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [WARM_CNT_W-1:0] r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    logic                  w_slot_free;
    logic                  w_accept;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !(r_state == ST_IDLE && w_slot_free);
    assign w_accept    = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == OP_INIT) begin
                        o_cmd.load_init = 1'b1;
                        n_count         = '0;
                        n_state         = ST_WARM;
                    end else begin
                        o_cmd.run_data = 1'b1;
                        n_out_valid    = 1'b1;
                    end
                end
            end
            ST_WARM: begin
                o_cmd.run_warm = 1'b1;
                n_count        = r_count + 1'b1;
                if (r_count == WARM_CNT_W'(WARM_ROUNDS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    o_cmd.set_init_out = 1'b1;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // no new request while an init is in flight
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("request accepted while busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WARM) |-> (r_count < WARM_CNT_W'(WARM_ROUNDS)))
        else $error("warm-up count out of range");

    a_done_posts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_slot_free) |=> (r_state == ST_IDLE && r_out_valid))
        else $error("init result not posted");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("conflicting datapath commands");

endmodule

### rtl/trivium_stream_cipher.sv
// trivium stream cipher top level, 80-bit key and iv
// data request: result registered in the cycle after accept, one word per cycle
//   when the result side does not stall
// init request: load, then warm-up steps of 32 rounds each, then the result is
//   registered once the result side does not stall; no request taken meanwhile
// reset: synchronous active low, clears state, key and iv, lengths to ten
module trivium_stream_cipher import trv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_word,
    output logic        o_init_done
);

    t_cmd w_cmd;

    trv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    trv_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_data_word   (i_data_word),
        .i_byte_count  (i_byte_count),
        .o_result_word (o_result_word),
        .o_init_done   (o_init_done)
    );

endmodule
